@@ sv/linked_deque_with_cursor_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the linked deque block
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LINKED_DEQUE_WITH_CURSOR_TOP_DEFINES_SVH
`define LINKED_DEQUE_WITH_CURSOR_TOP_DEFINES_SVH

// same-cycle implication
`define LDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ldq_pkg.sv @@
// ----------------------------------------------------------------------------
// ldq_pkg
// Types and constants shared by the linked deque modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ldq_pkg;

  localparam int unsigned POOL_DEPTH  = 64;
  localparam int unsigned IDX_W       = $clog2(POOL_DEPTH);
  localparam int unsigned LINK_W      = IDX_W + 1;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned REQ_W       = 4;
  localparam int unsigned CNT_W       = 7;

  // null link
  localparam logic [LINK_W-1:0] NIL = LINK_W'(POOL_DEPTH);

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 4'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_BACK  = 4'd5;
  localparam logic [REQ_W-1:0] REQ_REWIND     = 4'd6;
  localparam logic [REQ_W-1:0] REQ_NEXT       = 4'd7;
  localparam logic [REQ_W-1:0] REQ_GET        = 4'd8;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 4'd9;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] den;
    logic signed [VALUE_WIDTH-1:0] num;
  } entry_t;

  typedef struct packed {
    logic   pay_we;
    idx_t   pay_addr;
    entry_t pay_data;
    logic   nxt_we;
    idx_t   nxt_addr;
    link_t  nxt_data;
    logic   prv_we;
    idx_t   prv_addr;
    link_t  prv_data;
  } node_wr_t;

  typedef struct packed {
    entry_t pay;
    link_t  nxt;
    link_t  prv;
  } node_rd_t;

  typedef struct packed {
    logic rd;
    logic take;
    logic give;
    idx_t give_idx;
  } fs_ctrl_t;

  typedef struct packed {
    logic empty;
    idx_t idx;
  } fs_stat_t;

  function automatic logic is_node(link_t l);
    return l < NIL;
  endfunction

endpackage

`default_nettype wire

@@ sv/ldq_node_mem.sv @@
// ----------------------------------------------------------------------------
// ldq_node_mem
// Node pool: payload, next and prev link memories, one shared read address.
// ----------------------------------------------------------------------------
`default_nettype none

module ldq_node_mem import ldq_pkg::*; (
  input  logic     clk_i,
  input  logic     rd_en_i,
  input  idx_t     rd_addr_i,
  input  node_wr_t wr_i,
  output node_rd_t rd_o
);

  entry_t   pay_q [POOL_DEPTH];
  link_t    nxt_q [POOL_DEPTH];
  link_t    prv_q [POOL_DEPTH];
  node_rd_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.pay_we) pay_q[wr_i.pay_addr] <= wr_i.pay_data;
    if (wr_i.nxt_we) nxt_q[wr_i.nxt_addr] <= wr_i.nxt_data;
    if (wr_i.prv_we) prv_q[wr_i.prv_addr] <= wr_i.prv_data;
    if (rd_en_i) begin
      rd_q.pay <= pay_q[rd_addr_i];
      rd_q.nxt <= nxt_q[rd_addr_i];
      rd_q.prv <= prv_q[rd_addr_i];
    end
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

@@ sv/ldq_free_stack.sv @@
// ----------------------------------------------------------------------------
// ldq_free_stack
// Stack of free node indices in a memory, read at top-1 through a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ldq_free_stack import ldq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  fs_ctrl_t ctrl_i,
  output fs_stat_t stat_o
);

  idx_t  mem_q [POOL_DEPTH];
  idx_t  rd_data_q;
  link_t rd_pos_q;
  link_t top_q, top_d;
  link_t low_q, low_d;   // lowest top seen; slots below it have never been written
  link_t top_m1;

  assign top_m1 = top_q - LINK_W'(1);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.give) mem_q[top_q[IDX_W-1:0]] <= ctrl_i.give_idx;
    if (ctrl_i.rd) begin
      rd_data_q <= mem_q[top_m1[IDX_W-1:0]];
      rd_pos_q  <= top_m1;
    end
  end

  always_comb begin
    top_d = top_q;
    low_d = low_q;
    if (ctrl_i.take) begin
      top_d = top_m1;
      if (top_m1 < low_q) low_d = top_m1;
    end else if (ctrl_i.give) begin
      top_d = top_q + LINK_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= NIL;
      low_q <= NIL;
    end else begin
      top_q <= top_d;
      low_q <= low_d;
    end
  end

  // slots below the low mark are never written; their content is taken as the slot number
  assign stat_o.empty = (top_q == '0);
  assign stat_o.idx   = (rd_pos_q < low_q) ? rd_pos_q[IDX_W-1:0] : rd_data_q;

endmodule

`default_nettype wire

@@ sv/linked_deque_with_cursor_top.sv @@
// ----------------------------------------------------------------------------
// linked_deque_with_cursor_top
// Double-ended queue of rational entries held as a linked list in a node pool.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i/in_ready_o) carries req_type_i and, for a push,
//   the numerator and denominator. Result channel (out_valid_o/out_ready_i)
//   returns exactly one item per request: ok, the value read, the entry count
//   and whether the cursor points at an entry.
//   One request is in work at a time. The node memories are read in the
//   accept cycle, modified and written back in the next: a push passes
//   through EXEC and LINK, writing the neighbor's link in LINK on the same
//   memory port, other requests through EXEC only, then all wait in DONE.
//   A new request is accepted only once the last one has left DONE.
//   The result register decouples the channels: a new request is accepted
//   while the last result waits; if the receiver stalls, the next result
//   holds in its final state and in_ready_o stays low until it moves out.
//   Reset empties the queue, marks every node free and invalidates the
//   cursor; it needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_deque_with_cursor_top import ldq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [REQ_W-1:0]         req_type_i,
  input  logic signed [DATA_W-1:0] in_numerator_i,
  input  logic signed [DATA_W-1:0] in_denominator_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     ok_o,
  output logic signed [DATA_W-1:0] out_numerator_o,
  output logic signed [DATA_W-1:0] out_denominator_o,
  output logic [CNT_W-1:0]         entry_count_o,
  output logic                     cursor_valid_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_LINK = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]       state_q, state_d;
  link_t            front_q, front_d;
  link_t            back_q, back_d;
  link_t            count_q, count_d;
  link_t            cursor_q, cursor_d;

  logic [REQ_W-1:0] req_q;
  entry_t           item_q;
  link_t            tgt_q;
  link_t            tgt_sel;
  idx_t             new_q, new_d;
  link_t            old_end_q, old_end_d;
  logic             res_ok_q, res_ok_d;
  entry_t           res_val_q, res_val_d;

  logic             out_valid_q;
  logic             out_ok_q;
  entry_t           out_val_q;
  link_t            out_cnt_q;
  logic             out_cv_q;

  logic             acc;
  logic             load;
  logic             unlink;
  link_t            nxt_cur;
  node_wr_t         nwr;
  node_rd_t         nrd;
  fs_ctrl_t         fs_ctrl;
  fs_stat_t         fs_stat;

  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign load       = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // node addressed by the request, read in the accept cycle
  always_comb begin
    unique case (req_type_i)
      REQ_POP_FRONT, REQ_PEEK_FRONT: tgt_sel = front_q;
      REQ_POP_BACK,  REQ_PEEK_BACK:  tgt_sel = back_q;
      default:                       tgt_sel = cursor_q;
    endcase
  end

  ldq_node_mem u_node_mem (
    .clk_i     (clk_i),
    .rd_en_i   (acc),
    .rd_addr_i (tgt_sel[IDX_W-1:0]),
    .wr_i      (nwr),
    .rd_o      (nrd)
  );

  ldq_free_stack u_free_stack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (fs_ctrl),
    .stat_o (fs_stat)
  );

  assign nxt_cur = is_node(cursor_q) ? nrd.nxt : cursor_q;

  always_comb begin
    state_d   = state_q;
    front_d   = front_q;
    back_d    = back_q;
    count_d   = count_q;
    cursor_d  = cursor_q;
    new_d     = new_q;
    old_end_d = old_end_q;
    res_ok_d  = res_ok_q;
    res_val_d = res_val_q;
    unlink    = 1'b0;
    nwr       = '0;
    fs_ctrl   = '0;
    fs_ctrl.rd       = acc;
    fs_ctrl.give_idx = tgt_q[IDX_W-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (acc) state_d = ST_EXEC;
      end

      ST_EXEC: begin
        res_ok_d  = 1'b0;
        res_val_d = '0;
        state_d   = ST_DONE;
        unique case (req_q)
          REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            if (!fs_stat.empty && count_q < NIL) begin
              fs_ctrl.take = 1'b1;
              new_d        = fs_stat.idx;
              res_ok_d     = 1'b1;
              count_d      = count_q + LINK_W'(1);
              state_d      = ST_LINK;
              nwr.pay_we   = 1'b1;
              nwr.pay_addr = fs_stat.idx;
              nwr.pay_data = item_q;
              nwr.nxt_we   = 1'b1;
              nwr.nxt_addr = fs_stat.idx;
              nwr.prv_we   = 1'b1;
              nwr.prv_addr = fs_stat.idx;
              if (req_q == REQ_PUSH_FRONT) begin
                nwr.prv_data = NIL;
                nwr.nxt_data = front_q;
                old_end_d    = front_q;
                front_d      = {1'b0, fs_stat.idx};
                if (!is_node(front_q)) back_d = {1'b0, fs_stat.idx};
              end else begin
                nwr.nxt_data = NIL;
                nwr.prv_data = back_q;
                old_end_d    = back_q;
                back_d       = {1'b0, fs_stat.idx};
                if (!is_node(back_q)) front_d = {1'b0, fs_stat.idx};
              end
            end
          end
          REQ_POP_FRONT, REQ_POP_BACK: begin
            if (count_q != '0 && is_node(tgt_q)) begin
              res_ok_d  = 1'b1;
              res_val_d = nrd.pay;
              unlink    = 1'b1;
              if (cursor_q == tgt_q) cursor_d = NIL;
            end
          end
          REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
            if (count_q != '0 && is_node(tgt_q)) begin
              res_ok_d  = 1'b1;
              res_val_d = nrd.pay;
            end
          end
          REQ_REWIND: begin
            cursor_d = front_q;
            res_ok_d = is_node(front_q);
          end
          REQ_NEXT: begin
            cursor_d = nxt_cur;
            res_ok_d = is_node(nxt_cur);
          end
          REQ_GET: begin
            if (is_node(cursor_q)) begin
              res_ok_d  = 1'b1;
              res_val_d = nrd.pay;
            end
          end
          REQ_REMOVE: begin
            if (is_node(tgt_q)) begin
              cursor_d = is_node(nrd.nxt) ? nrd.nxt : nrd.prv;
              unlink   = 1'b1;
              res_ok_d = (count_q != LINK_W'(1));
            end
          end
          default: ;
        endcase

        // splice the node out and hand it back to the free stack
        if (unlink) begin
          if (is_node(nrd.prv)) begin
            nwr.nxt_we   = 1'b1;
            nwr.nxt_addr = nrd.prv[IDX_W-1:0];
            nwr.nxt_data = nrd.nxt;
          end else begin
            front_d = nrd.nxt;
          end
          if (is_node(nrd.nxt)) begin
            nwr.prv_we   = 1'b1;
            nwr.prv_addr = nrd.nxt[IDX_W-1:0];
            nwr.prv_data = nrd.prv;
          end else begin
            back_d = nrd.prv;
          end
          count_d      = count_q - LINK_W'(1);
          fs_ctrl.give = 1'b1;
        end
      end

      ST_LINK: begin
        // point the old end node at the new one
        if (is_node(old_end_q)) begin
          if (req_q == REQ_PUSH_FRONT) begin
            nwr.prv_we   = 1'b1;
            nwr.prv_addr = old_end_q[IDX_W-1:0];
            nwr.prv_data = {1'b0, new_q};
          end else begin
            nwr.nxt_we   = 1'b1;
            nwr.nxt_addr = old_end_q[IDX_W-1:0];
            nwr.nxt_data = {1'b0, new_q};
          end
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (load) state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      front_q     <= NIL;
      back_q      <= NIL;
      count_q     <= '0;
      cursor_q    <= NIL;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      front_q  <= front_d;
      back_q   <= back_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_q      <= req_type_i;
      item_q.num <= in_numerator_i[VALUE_WIDTH-1:0];
      item_q.den <= in_denominator_i[VALUE_WIDTH-1:0];
      tgt_q      <= tgt_sel;
    end
    new_q     <= new_d;
    old_end_q <= old_end_d;
    res_ok_q  <= res_ok_d;
    res_val_q <= res_val_d;
    if (load) begin
      out_ok_q  <= res_ok_q;
      out_val_q <= res_val_q;
      out_cnt_q <= count_q;
      out_cv_q  <= is_node(cursor_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign ok_o              = out_ok_q;
  assign out_numerator_o   = DATA_W'(signed'(out_val_q.num));
  assign out_denominator_o = DATA_W'(signed'(out_val_q.den));
  assign entry_count_o     = CNT_W'(out_cnt_q);
  assign cursor_valid_o    = out_cv_q;

endmodule

`default_nettype wire

@@ sv/ldq_checker.sv @@
// ----------------------------------------------------------------------------
// ldq_checker
// Port-level checks on the result channel of the linked deque.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linked_deque_with_cursor_top_defines.svh"

module ldq_checker import ldq_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_i,
  input logic                     out_ready_i,
  input logic                     ok_i,
  input logic signed [DATA_W-1:0] out_numerator_i,
  input logic signed [DATA_W-1:0] out_denominator_i,
  input logic [CNT_W-1:0]         entry_count_i,
  input logic                     cursor_valid_i
);

  // a stalled result holds
  `LDQ_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(ok_i) && $stable(out_numerator_i) && $stable(out_denominator_i) && $stable(entry_count_i) && $stable(cursor_valid_i), "result changed while stalled")

  // never more entries than nodes
  `LDQ_ASSERT_IMP(a_count_bound, out_valid_i, entry_count_i <= CNT_W'(POOL_DEPTH), "entry count beyond pool depth")

  // a valid cursor needs an entry to point at
  `LDQ_ASSERT_IMP(a_cursor_nonempty, out_valid_i && cursor_valid_i, entry_count_i != '0, "cursor valid on empty queue")

endmodule

bind linked_deque_with_cursor_top ldq_checker u_ldq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .ok_i              (ok_o),
  .out_numerator_i   (out_numerator_o),
  .out_denominator_i (out_denominator_o),
  .entry_count_i     (entry_count_o),
  .cursor_valid_i    (cursor_valid_o)
);

`default_nettype wire
